// ===== hw/rtl/lrukv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lrukv_pkg;

  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CAP_W      = 5;

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // One request beat.
  typedef struct packed {
    logic                  req_type;   // REQ_GET or REQ_PUT
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  // Update broadcast to the cells.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_TOUCH,   // hit: promote matching cell
    ACT_EVICT,   // replace least recent cell
    ACT_FILL     // take the next free cell
  } act_t;

  typedef struct packed {
    act_t                  act;
    logic                  put;        // write value into the selected cell
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  // Lookup data rippled along the row of cells.
  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] value;
    logic [KEY_BITS-1:0]   vkey;
  } chain_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrukv_cell.sv =====
// One cache entry: key, value, valid bit and recency rank.
`default_nettype none

module lrukv_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [lrukv_pkg::KEY_BITS-1:0]    lkey,
  input  wire logic [IW-1:0]                     victim_rank,
  input  wire logic [IW-1:0]                     old_rank,
  input  wire logic [IW-1:0]                     slot,
  input  wire lrukv_pkg::cmd_t                   cmd,
  input  wire lrukv_pkg::chain_t                 chain_in,
  input  wire logic [IW-1:0]                     rank_in,
  output lrukv_pkg::chain_t                      chain_out,
  output logic [IW-1:0]                          rank_out
);

  logic [lrukv_pkg::KEY_BITS-1:0]   key;
  logic [lrukv_pkg::VALUE_BITS-1:0] value;
  logic                             valid;
  logic [IW-1:0]                    rank;

  logic match;
  logic victim;
  logic sel;
  logic bump;

  assign match  = valid && (key == lkey);
  assign victim = valid && (rank == victim_rank);

  always_comb begin
    case (cmd.act)
      lrukv_pkg::ACT_TOUCH: sel = match;
      lrukv_pkg::ACT_EVICT: sel = victim;
      lrukv_pkg::ACT_FILL:  sel = (slot == IW'(IDX));
      default:              sel = 1'b0;
    endcase
  end

  // fill ages every valid entry; touch/evict only those more recent than the target
  assign bump = valid && !sel &&
                ((cmd.act == lrukv_pkg::ACT_FILL) ||
                 (((cmd.act == lrukv_pkg::ACT_TOUCH) || (cmd.act == lrukv_pkg::ACT_EVICT)) &&
                  (rank < old_rank)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (sel) begin
      rank <= '0;
      if (cmd.act == lrukv_pkg::ACT_FILL) begin
        valid <= 1'b1;
      end
    end else if (bump) begin
      rank <= rank + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.put) begin
      value <= cmd.value;
    end
    if (sel && ((cmd.act == lrukv_pkg::ACT_EVICT) || (cmd.act == lrukv_pkg::ACT_FILL))) begin
      key <= cmd.key;
    end
  end

  // keys are unique among valid entries, so at most one cell ORs in
  always_comb begin
    chain_out.hit   = chain_in.hit | match;
    chain_out.value = chain_in.value | (match ? value : '0);
    chain_out.vkey  = chain_in.vkey | (victim ? key : '0);
    rank_out        = rank_in | (match ? rank : '0);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key-value cache.
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
//
// Request channel: a beat is taken when start is high and busy is low. req
// carries req_type (0 get, 1 put), key and value.
// Result channel: result_valid strobes for one cycle with result (hit,
// read_value, evicted, evicted_key). The receiver cannot stall; every result
// beat is final when shown.
// Config channel: cfg_valid/cfg_ready/cfg_data write the capacity register
// (0 acts as 1, above ENTRIES acts as ENTRIES). cfg_ready is always high.
//
// Timing: a taken request is registered in req_q and compared against every
// cell in the lookup state; the update is applied and the result registered
// as lookup ends; result_valid strobes in the cycle after. busy is high in
// lookup only, so no request is taken then. Lookup is one ripple through
// the row of cells for the match, then the rank update broadcast back to it.
//
// Reset clears valid bits, ranks and the used count; capacity resets to 16.
// Valid cells always occupy the lowest slots, so the next free slot is the
// used count and the least recent entry holds rank used-1.
module lru_key_value_cache_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire lrukv_pkg::req_t               req,
  output logic                               result_valid,
  output lrukv_pkg::rsp_t                    result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lrukv_pkg::CAP_W-1:0]   cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > lrukv_pkg::CAP_W) ? CW : lrukv_pkg::CAP_W;

  lrukv_pkg::state_t state, state_next;
  lrukv_pkg::req_t   req_q;
  lrukv_pkg::rsp_t   rsp_next;
  lrukv_pkg::cmd_t   cmd;

  logic [lrukv_pkg::CAP_W-1:0] capacity;
  logic [CW-1:0]               used, used_next;
  logic [XW-1:0]               eff_cap;
  logic                        full;
  logic [IW-1:0]               victim_rank;
  logic [IW-1:0]               old_rank;
  logic [IW-1:0]               fill_slot;

  lrukv_pkg::chain_t link [0:ENTRIES];
  logic [IW-1:0]     rank_link [0:ENTRIES];

  logic accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Effective capacity, clamped to 1..ENTRIES.
  always_comb begin
    if (XW'(capacity) == '0) begin
      eff_cap = XW'(1);
    end else if (XW'(capacity) > XW'(ENTRIES)) begin
      eff_cap = XW'(ENTRIES);
    end else begin
      eff_cap = XW'(capacity);
    end
  end

  assign full        = XW'(used) >= eff_cap;
  assign victim_rank = IW'(used - 1'b1);
  assign fill_slot   = IW'(used);

  // Row of cells.
  assign link[0]      = '0;
  assign rank_link[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrukv_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .lkey        (req_q.key),
      .victim_rank (victim_rank),
      .old_rank    (old_rank),
      .slot        (fill_slot),
      .cmd         (cmd),
      .chain_in    (link[i]),
      .rank_in     (rank_link[i]),
      .chain_out   (link[i+1]),
      .rank_out    (rank_link[i+1])
    );
  end

  // Next state.
  always_comb begin
    case (state)
      lrukv_pkg::ST_IDLE: state_next = accept ? lrukv_pkg::ST_LOOK : lrukv_pkg::ST_IDLE;
      lrukv_pkg::ST_LOOK: state_next = lrukv_pkg::ST_IDLE;
      default:            state_next = lrukv_pkg::ST_IDLE;
    endcase
  end

  // Outputs: decide the update and build the result during lookup.
  always_comb begin
    busy      = 1'b0;
    cmd.act   = lrukv_pkg::ACT_NONE;
    cmd.put   = 1'b0;
    cmd.key   = req_q.key;
    cmd.value = req_q.value;
    old_rank  = rank_link[ENTRIES];
    used_next = used;
    rsp_next  = '0;
    case (state)
      lrukv_pkg::ST_LOOK: begin
        busy         = 1'b1;
        rsp_next.hit = link[ENTRIES].hit;
        if (link[ENTRIES].hit) begin
          cmd.act = lrukv_pkg::ACT_TOUCH;
          cmd.put = (req_q.req_type == lrukv_pkg::REQ_PUT);
          if (req_q.req_type == lrukv_pkg::REQ_GET) begin
            rsp_next.read_value = link[ENTRIES].value;
          end
        end else if (req_q.req_type == lrukv_pkg::REQ_PUT) begin
          cmd.put = 1'b1;
          if (full) begin
            cmd.act              = lrukv_pkg::ACT_EVICT;
            old_rank             = victim_rank;
            rsp_next.evicted     = 1'b1;
            rsp_next.evicted_key = link[ENTRIES].vkey;
          end else begin
            cmd.act   = lrukv_pkg::ACT_FILL;
            used_next = used + 1'b1;
          end
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lrukv_pkg::ST_IDLE;
      used         <= '0;
      capacity     <= lrukv_pkg::CAP_W'(16);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      used         <= used_next;
      result_valid <= (state == lrukv_pkg::ST_LOOK);
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (state == lrukv_pkg::ST_LOOK) begin
      result <= rsp_next;
    end
  end

  // Checks.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request taken but lookup did not start");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_no_hit_evict: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.hit && result.evicted))
    else $error("hit and eviction on the same request");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.evicted) |-> (used == $past(used)))
    else $error("eviction changed the used count");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(used) <= XW'(ENTRIES))
    else $error("used count beyond entry count");

endmodule

`default_nettype wire

// ===== test/lrukv_checker.sv =====
`timescale 1ns / 1ps
// Shadow LRU cache model and result scoreboard for the key-value cache.
module lrukv_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire lrukv_pkg::req_t               req,
  input  wire logic                          result_valid,
  input  wire lrukv_pkg::rsp_t               result,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [lrukv_pkg::CAP_W-1:0]   cfg_data,
  output int                                 fail_count,
  output int                                 results_due
);
  import lrukv_pkg::*;

  localparam int   SLOTS   = 16;

  logic [KEY_BITS-1:0]   slot_key [SLOTS];
  logic [VALUE_BITS-1:0] slot_val [SLOTS];
  bit                    slot_live[SLOTS];
  int unsigned           slot_age [SLOTS];   // 0 = most recent
  int unsigned           live_count;
  logic [CAP_W-1:0]      cap_reg;
  rsp_t                  due_rsp[$];
  int                    err_tally = 0;

  // Move slot s to the front; everything newer than it ages by one.
  function automatic void bump_to_front(input int s);
    int unsigned old_age;
    old_age = slot_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Apply one request to the shadow cache and return the result it should give.
  function automatic void cache_access(input req_t r, output rsp_t e);
    int unsigned lim;
    int          found;
    int          oldest;
    int          free_slot;
    e     = '0;
    lim   = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
    found = -1;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && slot_live[i] && slot_key[i] == r.key) found = i;

    if (found >= 0) begin
      e.hit = 1'b1;
      if (r.req_type == REQ_GET) e.read_value = slot_val[found];
      else slot_val[found] = r.value;
      bump_to_front(found);
    end else if (r.req_type == REQ_PUT) begin
      if (live_count >= lim) begin
        // full (or capacity lowered): replace the oldest entry in place
        oldest = -1;
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
        if (oldest >= 0) begin
          e.evicted       = 1'b1;
          e.evicted_key   = slot_key[oldest];
          slot_key[oldest] = r.key;
          slot_val[oldest] = r.value;
          bump_to_front(oldest);
        end
      end else begin
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!slot_live[i] && free_slot < 0) free_slot = i;
        if (free_slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_live[i]) slot_age[i]++;
          slot_live[free_slot] = 1'b1;
          slot_key[free_slot]  = r.key;
          slot_val[free_slot]  = r.value;
          slot_age[free_slot]  = 0;
          live_count++;
        end
      end
    end
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t lrukv_checker: %s expected %h got %h", $time, what, want, got);
      err_tally++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      live_count = 0;
      cap_reg    = 5'd16;
      due_rsp.delete();
    end else begin
      // retire before predicting: a result never belongs to a beat taken this edge
      if (result_valid) begin
        if (due_rsp.size() == 0) begin
          $display("%0t lrukv_checker: unexpected result %h", $time, result);
          err_tally++;
        end else begin
          want = due_rsp.pop_front();
          check_field("hit", 32'(want.hit), 32'(result.hit));
          check_field("read_value", want.read_value, result.read_value);
          check_field("evicted", 32'(want.evicted), 32'(result.evicted));
          check_field("evicted_key", 32'(want.evicted_key), 32'(result.evicted_key));
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (start && !busy) begin
        cache_access(req, want);
        due_rsp.insert(due_rsp.size(), want);
      end
    end
    fail_count  <= err_tally;
    results_due <= due_rsp.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the LRU key-value cache testbench: stimulus, watchdog and verdict.
module testbench;
  import lrukv_pkg::*;

  localparam int   QUIET_LIMIT = 2000;  // far above the longest sender gap plus latency
  localparam int   SEGMENTS    = 10;
  localparam int   SEG_ITEMS   = 75;
  localparam int   POOL        = 20;    // more keys than slots, so evictions keep coming
  localparam int   DRAIN_WAIT  = 3;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  req_t             req       = '0;
  logic             result_valid;
  rsp_t             result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;
  int               fail_count;
  int               results_due;
  int               quiet_cycles = 0;

  logic [KEY_BITS-1:0] key_pool[POOL];
  // Capacity per random segment: shrinks below the fill level, zero, above range.
  logic [CAP_W-1:0] cap_plan[SEGMENTS] =
    '{5'd3, 5'd16, 5'd1, 5'd31, 5'd8, 5'd0, 5'd17, 5'd12, 5'd2, 5'd16};

  initial begin
    forever #2 clk = ~clk;
  end

  lru_key_value_cache_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  lrukv_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_due  (results_due)
  );

  function automatic req_t make_req(input logic op, input logic [KEY_BITS-1:0] k,
                                    input logic [VALUE_BITS-1:0] v);
    req_t r;
    r.req_type = op;
    r.key      = k;
    r.value    = v;
    return r;
  endfunction

  // Mostly keys from the small pool (hits, updates, evictions), some fresh ones.
  function automatic req_t random_req();
    req_t r;
    r.req_type = 1'($urandom_range(1));
    r.value    = $urandom;
    r.key      = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL-1)]
                                            : KEY_BITS'($urandom);
    return r;
  endfunction

  // Hold the beat on the request port until the cache takes it. start stays
  // high on return so back-to-back beats are taken as fast as the cache allows.
  task automatic send_beat(input req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Sender gap, taken with pct percent odds, with junk on the request bus.
  task automatic idle_gap(input int pct);
    req_t junk;
    if ($urandom_range(99) < pct) begin
      junk.req_type = 1'($urandom_range(1));
      junk.key      = KEY_BITS'($urandom);
      junk.value    = $urandom;
      start <= 1'b0;
      req   <= junk;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Capacity only changes with the cache drained and quiet. The wait before
  // polling lets the scoreboard count the beat just taken.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Watchdog: any taken request, result strobe or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int pct;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset capacity of 16 ---
    send_beat(make_req(REQ_GET, 16'h0000, 32'h0));           // get on an empty cache
    send_beat(make_req(REQ_PUT, 16'h0000, 32'h0000_0000));   // lowest key and value
    send_beat(make_req(REQ_PUT, 16'hFFFF, 32'hFFFF_FFFF));   // highest key and value
    send_beat(make_req(REQ_GET, 16'h0000, 32'hFFFF_FFFF));   // hit, value ignored
    send_beat(make_req(REQ_GET, 16'hFFFF, 32'h0));
    send_beat(make_req(REQ_PUT, 16'h0000, 32'hA5A5_5A5A));   // put hit: update only
    send_beat(make_req(REQ_GET, 16'h1234, 32'h0));           // miss with entries present
    for (int i = 0; i < 14; i++)                             // fill all 16 slots
      send_beat(make_req(REQ_PUT, KEY_BITS'(16'h0100 + i), $urandom));
    send_beat(make_req(REQ_PUT, 16'h7777, 32'h1357_9BDF));   // full: evicts 0xFFFF
    send_beat(make_req(REQ_GET, 16'h0000, 32'h0));

    // capacity dropped below the fill level: each new key evicts one, count holds
    set_capacity(5'd2);
    send_beat(make_req(REQ_PUT, 16'h2000, $urandom));
    send_beat(make_req(REQ_PUT, 16'h2001, $urandom));
    send_beat(make_req(REQ_GET, 16'h2001, 32'h0));

    // zero acts as one
    set_capacity(5'd0);
    send_beat(make_req(REQ_PUT, 16'h3000, $urandom));
    send_beat(make_req(REQ_GET, 16'h3000, 32'h0));

    // --- random segments, each with its own capacity and key pool ---
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_capacity(cap_plan[seg]);
      pct = (seg < 4) ? 23 : ((seg < 7) ? 56 : 0);
      for (int p = 0; p < POOL; p++) key_pool[p] = KEY_BITS'($urandom);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        send_beat(random_req());
        idle_gap(pct);
      end
    end

    // --- drain and verdict ---
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
